[hdl/ifb_pkg.sv]
// Package for the indexed framebuffer blitter: frame geometry, command codes,
// the queued command type and the fixed RGB565 palette. No dependencies.
package ifb_pkg;

    localparam int FRAME_WIDTH  = 160;
    localparam int FRAME_HEIGHT = 128;
    localparam int CELLS        = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W       = $clog2(CELLS);
    localparam int ROW_W        = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;
    localparam int Q_DEPTH      = 4;
    localparam int Q_PTR_W      = $clog2(Q_DEPTH);

    localparam logic [2:0] MODE_PLOT  = 3'd0;
    localparam logic [2:0] MODE_RECT  = 3'd1;
    localparam logic [2:0] MODE_BLITS = 3'd2;
    localparam logic [2:0] MODE_BLITP = 3'd3;
    localparam logic [2:0] MODE_SCAN  = 3'd4;

    // Command handed from the front part to the back part
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_RECT  = 2'd1,
        OP_SCAN  = 2'd2
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] x_end;
        logic [7:0] y_end;
        logic [7:0] idx;
    } t_cmd;

    function automatic logic [15:0] pal_lookup(input logic [7:0] idx);
        logic [15:0] c;
        case (idx)
            8'd0: c = 16'h0000; 8'd1: c = 16'h0000; 8'd2: c = 16'hffff; 8'd3: c = 16'hf800;
            8'd4: c = 16'h07e0; 8'd5: c = 16'h001f; 8'd6: c = 16'hffff; 8'd7: c = 16'hffff;
            8'd8: c = 16'h4167; 8'd9: c = 16'h59a8; 8'd10: c = 16'h7a29; 8'd11: c = 16'ha2ca;
            8'd12: c = 16'hbbcb; 8'd13: c = 16'hed0c; 8'd14: c = 16'hf674; 8'd15: c = 16'hb6a7;
            8'd16: c = 16'h7546; 8'd17: c = 16'h3bc8; 8'd18: c = 16'h3aca; 8'd19: c = 16'h3165;
            8'd20: c = 16'h5a8a; 8'd21: c = 16'h7b8e; 8'd22: c = 16'ha491; 8'd23: c = 16'hce37;
            8'd24: c = 16'hdfbe; 8'd25: c = 16'h8f5e; 8'd26: c = 16'h2e7b; 8'd27: c = 16'h3bd5;
            8'd28: c = 16'h3a2f; 8'd29: c = 16'h3989; 8'd30: c = 16'h520c; 8'd31: c = 16'h8a31;
            8'd32: c = 16'hcb12; 8'd33: c = 16'hfd76; 8'd34: c = 16'hf5a3; 8'd35: c = 16'hf3e3;
            8'd36: c = 16'he245; 8'd37: c = 16'ha9c7; 8'd38: c = 16'h8392; 8'd39: c = 16'h4aad;
            8'd40: c = 16'h20a3; 8'd41: c = 16'h28c4; 8'd42: c = 16'h3904; 8'd43: c = 16'h5165;
            8'd44: c = 16'h59e5; 8'd45: c = 16'h7286; 8'd46: c = 16'h7b2a; 8'd47: c = 16'h5b43;
            8'd48: c = 16'h3aa3; 8'd49: c = 16'h19e4; 8'd50: c = 16'h1965; 8'd51: c = 16'h18a2;
            8'd52: c = 16'h2945; 8'd53: c = 16'h39c7; 8'd54: c = 16'h5248; 8'd55: c = 16'h630b;
            8'd56: c = 16'h6bcf; 8'd57: c = 16'h43af; 8'd58: c = 16'h132d; 8'd59: c = 16'h19ea;
            8'd60: c = 16'h1907; 8'd61: c = 16'h18c4; 8'd62: c = 16'h2906; 8'd63: c = 16'h4127;
            8'd64: c = 16'h6189; 8'd65: c = 16'h7aab; 8'd66: c = 16'h7ac1; 8'd67: c = 16'h79e1;
            8'd68: c = 16'h7122; 8'd69: c = 16'h50e3; 8'd70: c = 16'h41c9; 8'd71: c = 16'h2146;
            default: c = 16'h0000;
        endcase
        return c;
    endfunction

endpackage

[hdl/ifb_front.sv]
// Front part: accepts commands, tracks blit and scan positions, clips
// coordinates and pushes classified commands into the queue. Uses ifb_pkg.
module ifb_front import ifb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic [2:0] i_mode,
    input  logic [7:0] i_pos_x,
    input  logic [7:0] i_pos_y,
    input  logic [7:0] i_span_w,
    input  logic [7:0] i_span_h,
    input  logic [7:0] i_color_idx,
    input  logic       i_q_full,
    output logic       o_q_push,
    output t_cmd       o_q_cmd
);

    logic [7:0]       r_bx, r_by, r_bw, r_bh, r_bcol, r_brow;
    logic             r_bact;
    logic [7:0]       r_scol;
    logic [ROW_W-1:0] r_srow;
    logic             accept;
    logic [8:0]       bpx, bpy, xe, ye;
    t_cmd             cmd;
    logic             keep;

    assign o_full = i_q_full;
    assign accept = i_push && !i_q_full;
    assign bpx = {1'b0, r_bx} + {1'b0, r_bcol};
    assign bpy = {1'b0, r_by} + {1'b0, r_brow};
    assign xe  = {1'b0, i_pos_x} + {1'b0, i_span_w};
    assign ye  = {1'b0, i_pos_y} + {1'b0, i_span_h};

    // Classify the item into a back-end command
    always_comb begin
        cmd = '{op: OP_WRITE, x: i_pos_x, y: i_pos_y, x_end: 8'd0, y_end: 8'd0,
                idx: i_color_idx};
        keep = 1'b0;
        case (i_mode)
            MODE_PLOT: begin
                keep = (i_pos_x < 8'(FRAME_WIDTH)) && ({1'b0, i_pos_y} < 9'(FRAME_HEIGHT));
            end
            MODE_RECT: begin
                cmd.op = OP_RECT;
                cmd.x_end = (xe > 9'(FRAME_WIDTH)) ? 8'(FRAME_WIDTH) : xe[7:0];
                cmd.y_end = (ye > 9'(FRAME_HEIGHT)) ? 8'(FRAME_HEIGHT) : ye[7:0];
                keep = (i_pos_x < 8'(FRAME_WIDTH)) && ({1'b0, i_pos_y} < 9'(FRAME_HEIGHT))
                    && (i_span_w != 8'd0) && (i_span_h != 8'd0);
            end
            MODE_BLITP: begin
                cmd.x = bpx[7:0];
                cmd.y = bpy[7:0];
                keep = r_bact && (i_color_idx != 8'd0) && (bpx < 9'(FRAME_WIDTH))
                    && (bpy < 9'(FRAME_HEIGHT));
            end
            MODE_SCAN: begin
                cmd.op = OP_SCAN;
                cmd.x = r_scol;
                cmd.y = 8'(r_srow);
                cmd.x_end = {7'd0, (r_scol == 8'(FRAME_WIDTH - 1)) && (r_srow == '0)};
                keep = 1'b1;
            end
            default: keep = 1'b0;
        endcase
    end

    // Load and advance blit and scan positions on their transfers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bx <= '0; r_by <= '0; r_bw <= '0; r_bh <= '0;
            r_bcol <= '0; r_brow <= '0; r_bact <= 1'b0;
            r_scol <= '0; r_srow <= ROW_W'(FRAME_HEIGHT - 1);
            o_q_push <= 1'b0;
        end else begin
            o_q_push <= accept && keep;
            o_q_cmd <= cmd;
            if (accept && i_mode == MODE_BLITS) begin
                r_bx <= i_pos_x; r_by <= i_pos_y; r_bw <= i_span_w; r_bh <= i_span_h;
                r_bcol <= '0; r_brow <= '0;
                r_bact <= (i_span_w != 8'd0) && (i_span_h != 8'd0);
            end
            if (accept && i_mode == MODE_BLITP && r_bact) begin
                if ({1'b0, r_bcol} + 9'd1 >= {1'b0, r_bw}) begin
                    r_bcol <= '0;
                    if ({1'b0, r_brow} + 9'd1 >= {1'b0, r_bh}) begin
                        r_brow <= '0;
                        r_bact <= 1'b0;
                    end else begin
                        r_brow <= r_brow + 8'd1;
                    end
                end else begin
                    r_bcol <= r_bcol + 8'd1;
                end
            end
            if (accept && i_mode == MODE_SCAN) begin
                if (r_srow == '0) begin
                    r_srow <= ROW_W'(FRAME_HEIGHT - 1);
                    r_scol <= (r_scol == 8'(FRAME_WIDTH - 1)) ? 8'd0 : r_scol + 8'd1;
                end else begin
                    r_srow <= r_srow - 1'b1;
                end
            end
        end
    end

endmodule

[hdl/ifb_queue.sv]
// Short command queue between front and back parts. Uses ifb_pkg.
module ifb_queue import ifb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp, r_rp;
    logic [Q_PTR_W:0]   r_cnt;

    // Leave one slot of slack for the registered push of the front part
    assign o_full  = (r_cnt >= (Q_PTR_W+1)'(Q_DEPTH - 1));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_cmd;
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (Q_PTR_W+1)'(i_push) - (Q_PTR_W+1)'(i_pop);
        end
    end

endmodule

[hdl/ifb_back.sv]
// Back part: clearing pass, cell writes, rect sweep and scan reads through
// the palette into a result queue. Uses ifb_pkg.
module ifb_back import ifb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_empty,
    input  t_cmd        i_q_cmd,
    output logic        o_q_pop,
    output logic        o_busy_clear,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [15:0] o_rgb565,
    output logic        o_frame_end
);

    typedef enum logic [1:0] {ST_CLEAR, ST_RUN, ST_RECT} t_state;

    t_state            r_state;
    logic [ADDR_W-1:0] r_clr;
    logic [7:0]        r_x, r_y;
    logic [ADDR_W-1:0] r_rowbase;
    t_cmd              r_rc;
    logic [7:0]        mem [CELLS];
    logic [7:0]        r_rd;
    logic              r_rd_v, r_rd_end;
    logic [15:0]       r_oq_c [4];
    logic              r_oq_e [4];
    logic [1:0]        r_owp, r_orp;
    logic [2:0]        r_ocnt;
    logic              out_full, take, is_scan, rd_push;
    logic              we;
    logic [ADDR_W-1:0] waddr, caddr;
    logic [7:0]        wdata;

    // Outstanding scans: queued results plus one read in flight
    assign out_full = (r_ocnt + 3'(r_rd_v)) >= 3'd4;
    assign is_scan  = (i_q_cmd.op == OP_SCAN);
    assign take     = (r_state == ST_RUN) && !i_q_empty && !(is_scan && out_full);
    assign o_q_pop  = take;
    assign o_busy_clear = (r_state == ST_CLEAR);
    assign caddr = ADDR_W'(i_q_cmd.y) * ADDR_W'(FRAME_WIDTH) + ADDR_W'(i_q_cmd.x);
    assign rd_push = r_rd_v;

    // Select the store write for this cycle
    always_comb begin
        we = 1'b0; waddr = caddr; wdata = i_q_cmd.idx;
        case (r_state)
            ST_CLEAR: begin we = 1'b1; waddr = r_clr; wdata = 8'd0; end
            ST_RECT: begin
                we = 1'b1; waddr = r_rowbase + ADDR_W'(r_x); wdata = r_rc.idx;
            end
            default: we = take && (i_q_cmd.op == OP_WRITE);
        endcase
    end

    // Frame store
    always_ff @(posedge i_clk) begin
        if (we) mem[waddr] <= wdata;
        r_rd <= mem[caddr];
    end

    // Sequence clearing, rect sweep and scan reads
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR; r_clr <= '0; r_rd_v <= 1'b0;
        end else begin
            r_rd_v <= take && is_scan;
            r_rd_end <= i_q_cmd.x_end[0];
            case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == ADDR_W'(CELLS - 1)) r_state <= ST_RUN;
                end
                ST_RUN: begin
                    if (take && i_q_cmd.op == OP_RECT) begin
                        r_rc <= i_q_cmd;
                        r_x <= i_q_cmd.x;
                        r_y <= i_q_cmd.y;
                        r_rowbase <= caddr - ADDR_W'(i_q_cmd.x);
                        r_state <= ST_RECT;
                    end
                end
                ST_RECT: begin
                    if (r_x + 8'd1 >= r_rc.x_end) begin
                        r_x <= r_rc.x;
                        r_rowbase <= r_rowbase + ADDR_W'(FRAME_WIDTH);
                        r_y <= r_y + 8'd1;
                        if (r_y + 8'd1 >= r_rc.y_end) r_state <= ST_RUN;
                    end else begin
                        r_x <= r_x + 8'd1;
                    end
                end
                default: r_state <= ST_RUN;
            endcase
        end
    end

    // Result queue with palette lookup on entry
    assign o_empty     = (r_ocnt == 3'd0);
    assign o_rgb565    = r_oq_c[r_orp];
    assign o_frame_end = r_oq_e[r_orp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp <= '0; r_orp <= '0; r_ocnt <= '0;
        end else begin
            if (rd_push) begin
                r_oq_c[r_owp] <= pal_lookup(r_rd);
                r_oq_e[r_owp] <= r_rd_end;
                r_owp <= r_owp + 2'd1;
            end
            if (i_pop && !o_empty) r_orp <= r_orp + 2'd1;
            r_ocnt <= r_ocnt + 3'(rd_push) - 3'(i_pop && !o_empty);
        end
    end

endmodule

[hdl/indexed_framebuffer_blitter.sv]
// Indexed framebuffer blitter top: front part, command queue, back part.
// Plot, blit and scan items are taken while full is low; a rect fill holds the back part
// while its sweep writes the cells one by one. A scan result passes the front register,
// a queue slot, the store read and the result queue, with palette lookup on entry.
// After reset a clearing pass zeroes every cell of the store; full stays high during it.
// Synchronous active-low reset. Uses ifb_pkg.
module indexed_framebuffer_blitter import ifb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_mode,
    input  logic [7:0]  i_pos_x,
    input  logic [7:0]  i_pos_y,
    input  logic [7:0]  i_span_w,
    input  logic [7:0]  i_span_h,
    input  logic [7:0]  i_color_idx,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] o_rgb565,
    output logic        o_frame_end
);

    logic q_full, q_push, q_empty, q_pop, busy_clear, f_full;
    t_cmd q_cmd_in, q_cmd_out;

    assign full = f_full || busy_clear;

    ifb_front u_front (
        .i_clk, .i_rst_n, .i_push(push && !busy_clear), .o_full(f_full),
        .i_mode, .i_pos_x, .i_pos_y, .i_span_w, .i_span_h, .i_color_idx,
        .i_q_full(q_full), .o_q_push(q_push), .o_q_cmd(q_cmd_in)
    );

    ifb_queue u_queue (
        .i_clk, .i_rst_n, .i_push(q_push), .i_cmd(q_cmd_in), .o_full(q_full),
        .i_pop(q_pop), .o_empty(q_empty), .o_cmd(q_cmd_out)
    );

    ifb_back u_back (
        .i_clk, .i_rst_n, .i_q_empty(q_empty), .i_q_cmd(q_cmd_out), .o_q_pop(q_pop),
        .o_busy_clear(busy_clear), .o_empty(empty), .i_pop(pop),
        .o_rgb565, .o_frame_end
    );

endmodule
